FILE: sv/tlm_pkg.sv
// Shared types, constants and the quarter-wave sine table for the tremolo modulator.
// Used by tlm_ctrl, tlm_dp, tremolo_lfo_modulator and tb_top; depends on nothing else.
package tlm_pkg;

    localparam int SINE_DEPTH = 256;
    localparam int SINE_IDX_W = $clog2(SINE_DEPTH + 1);

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 17;
    localparam int PROD_W = MUL_A_W + MUL_B_W;

    localparam logic [31:0] PHASE_QUARTER = 32'h4000_0000;
    localparam logic [31:0] PHASE_HALF = 32'h8000_0000;
    localparam logic [31:0] PHASE_3QUARTER = 32'hC000_0000;
    localparam logic [31:0] EDGE_FALL = 32'd2061584303;
    localparam logic [31:0] EDGE_RISE = 32'd4209067951;
    localparam logic [16:0] LFO_ONE = 17'd65536;
    localparam logic [16:0] LFO_MID = 17'd32768;
    localparam logic [16:0] SLOPE_GAIN = 17'd50;
    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] STEP_RESET = 32'd536871;

    localparam logic [1:0] WAVE_TRIANGLE = 2'd0;
    localparam logic [1:0] WAVE_SQUARE = 2'd1;
    localparam logic [1:0] WAVE_SLOPED = 2'd2;
    localparam logic [1:0] WAVE_SINE = 2'd3;

    localparam logic REG_WAVEFORM = 1'b0;
    localparam logic REG_STEP = 1'b1;

    typedef enum logic [1:0] {
        MUL_SLOPE,
        MUL_DEPTH,
        MUL_SCALE,
        MUL_STEP
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     load_shape;
        logic     load_level;
        logic     load_result;
        logic     commit;
    } t_dp_cmd;

    typedef logic [16:0] t_sine_rom [0:SINE_DEPTH];

    // Taylor series through x^13 in Q2.30, each term truncated, then rounded to Q1.16.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom          rom;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x = (64'(HALF_PI_Q30) * 64'(k)) / SINE_DEPTH;
            x2 = (x * x) >> 30;
            sum = $signed(x);
            term = ((x * x2) >> 30) / 64'd6;
            sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum = sum + $signed(term);
            if (sum < 0) begin
                sum = 64'sd0;
            end
            v = ($unsigned(sum) + 64'd8192) >> 14;
            if (v > 64'(LFO_ONE)) begin
                v = 64'(LFO_ONE);
            end
            rom[k] = v[16:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_sine_rom();

endpackage

FILE: sv/tlm_ctrl.sv
// Sequencer for the tremolo modulator: steps one item through the shared multiplier.
// Depends on tlm_pkg for the datapath command struct.
module tlm_ctrl
    import tlm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHAPE,
        S_LEVEL,
        S_DEPTH,
        S_SCALE,
        S_STEP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && i_stall;
        o_cmd = '0;
        o_cmd.mul_sel = MUL_SLOPE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_SHAPE;
                end
            end
            S_SHAPE: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_sel = MUL_SLOPE;
                o_cmd.load_shape = 1'b1;
                n_state = S_LEVEL;
            end
            S_LEVEL: begin
                o_cmd.load_level = 1'b1;
                n_state = S_DEPTH;
            end
            S_DEPTH: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_sel = MUL_DEPTH;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_sel = MUL_SCALE;
                n_state = S_STEP;
            end
            S_STEP: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_sel = MUL_STEP;
                o_cmd.load_result = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: sv/tlm_dp.sv
// Datapath of the tremolo modulator: registers, LFO shapes, sine table and shared multiplier.
// Depends on tlm_pkg for constants, the sine table and the command struct.
module tlm_dp
    import tlm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic        [31:0] i_cfg_data,
    input  logic signed [15:0] i_sample_in,
    input  logic        [15:0] i_depth_knob,
    input  logic        [15:0] i_rate_knob,
    output logic signed [15:0] o_sample_out
);

    typedef enum logic [1:0] {
        SLOPE_NONE,
        SLOPE_FALL,
        SLOPE_RISE
    } t_slope;

    logic        [1:0]                 r_wave;
    logic        [31:0]                r_step_full;
    logic        [31:0]                r_phase;
    logic signed [15:0]                r_sample;
    logic        [15:0]                r_depth;
    logic        [15:0]                r_rate;
    logic        [PROD_W-1:0]          r_prod;
    logic        [16:0]                r_lfo;
    t_slope                            r_slope;
    logic        [15:0]                r_result;
    logic signed [15:0]                r_out;

    logic        [PROD_W-1:0]          n_prod;
    logic        [16:0]                n_lfo_base;
    t_slope                            n_slope;
    logic        [16:0]                n_lfo_level;
    logic        [15:0]                n_result;

    logic        [MUL_A_W-1:0]         w_mul_a;
    logic        [MUL_B_W-1:0]         w_mul_b;
    logic        [31:0]                w_slope_diff;
    logic        [29:0]                w_frac;
    logic        [29+SINE_IDX_W:0]     w_ix_prod;
    logic        [SINE_IDX_W-1:0]      w_ix;
    logic        [SINE_IDX_W-1:0]      w_rom_addr;
    logic        [16:0]                w_sine;
    logic        [16:0]                w_ext;
    logic        [16:0]                w_mag;
    logic                              w_neg;
    logic        [PROD_W-1:0]          w_rest;
    logic        [15:0]                w_scaled;

    assign w_slope_diff = (r_phase < PHASE_HALF) ? (r_phase - EDGE_FALL) : (r_phase - EDGE_RISE);
    assign w_neg = r_sample[15];
    assign w_ext = {r_sample[15], r_sample};
    assign w_mag = w_neg ? (~w_ext + 17'd1) : w_ext;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_SLOPE: begin
                w_mul_a = w_slope_diff;
                w_mul_b = SLOPE_GAIN;
            end
            MUL_DEPTH: begin
                w_mul_a = {15'd0, r_lfo};
                w_mul_b = {1'b0, r_depth};
            end
            MUL_SCALE: begin
                w_mul_a = r_prod[31:0];
                w_mul_b = w_mag;
            end
            MUL_STEP: begin
                w_mul_a = r_step_full;
                w_mul_b = {1'b0, r_rate};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        n_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    end

    assign w_frac = r_phase[29:0];
    assign w_ix_prod = (SINE_IDX_W + 30)'(w_frac) * (SINE_IDX_W + 30)'(SINE_DEPTH);
    assign w_ix = w_ix_prod[29+SINE_IDX_W:30];
    assign w_rom_addr = r_phase[30] ? (SINE_IDX_W'(SINE_DEPTH) - w_ix) : w_ix;
    assign w_sine = SINE_ROM[w_rom_addr];

    always_comb begin
        n_slope = SLOPE_NONE;
        case (r_wave)
            WAVE_TRIANGLE: begin
                if (r_phase < PHASE_QUARTER) begin
                    n_lfo_base = LFO_MID + 17'(r_phase >> 15);
                end else if (r_phase < PHASE_3QUARTER) begin
                    n_lfo_base = LFO_ONE - 17'((r_phase - PHASE_QUARTER) >> 15);
                end else begin
                    n_lfo_base = 17'((r_phase - PHASE_3QUARTER) >> 15);
                end
            end
            WAVE_SQUARE: begin
                n_lfo_base = (r_phase < PHASE_HALF) ? LFO_ONE : 17'd0;
            end
            WAVE_SLOPED: begin
                if (r_phase < EDGE_FALL) begin
                    n_lfo_base = LFO_ONE;
                end else if (r_phase < PHASE_HALF) begin
                    n_lfo_base = LFO_ONE;
                    n_slope = SLOPE_FALL;
                end else if (r_phase < EDGE_RISE) begin
                    n_lfo_base = 17'd0;
                end else begin
                    n_lfo_base = 17'd0;
                    n_slope = SLOPE_RISE;
                end
            end
            WAVE_SINE: begin
                if (!r_phase[31]) begin
                    n_lfo_base = LFO_MID + (w_sine >> 1);
                end else begin
                    n_lfo_base = LFO_MID - (w_sine >> 1);
                end
            end
            default: begin
                n_lfo_base = 17'd0;
            end
        endcase
    end

    always_comb begin
        case (r_slope)
            SLOPE_FALL: n_lfo_level = r_lfo - r_prod[32:16];
            SLOPE_RISE: n_lfo_level = r_lfo + r_prod[32:16];
            default:    n_lfo_level = r_lfo;
        endcase
    end

    assign w_rest = {w_mag, 32'd0} - r_prod;
    assign w_scaled = w_rest[47:32];
    assign n_result = w_neg ? (~w_scaled + 16'd1) : w_scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave <= WAVE_TRIANGLE;
            r_step_full <= STEP_RESET;
            r_phase <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WAVEFORM: r_wave <= i_cfg_data[1:0];
                    REG_STEP:     r_step_full <= i_cfg_data;
                    default:      r_wave <= r_wave;
                endcase
            end
            if (i_cmd.commit) begin
                r_phase <= r_phase + r_prod[47:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sample <= i_sample_in;
            r_depth <= i_depth_knob;
            r_rate <= i_rate_knob;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.load_shape) begin
            r_lfo <= n_lfo_base;
            r_slope <= n_slope;
        end
        if (i_cmd.load_level) begin
            r_lfo <= n_lfo_level;
        end
        if (i_cmd.load_result) begin
            r_result <= n_result;
        end
        if (i_cmd.commit) begin
            r_out <= $signed(r_result);
        end
    end

    assign o_sample_out = r_out;

endmodule

FILE: sv/tremolo_lfo_modulator.sv
// Top level of the tremolo modulator: joins the sequencer and the datapath.
// Depends on tlm_pkg, tlm_ctrl and tlm_dp.
//
//   Channel   Direction  Handshake           Payload
//   input     in         i_valid / o_stall   i_sample_in, i_depth_knob, i_rate_knob
//   output    out        o_valid / i_stall   o_sample_out
//   config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// After an item is accepted it passes the shape, level, depth, scale, step and done states,
// and reaches the output register as it leaves done; the next item is accepted only then:
// one shared 32x17 multiplier is used four times in sequence (slope, depth, scale, phase step).
// A new item is accepted while the previous result still waits on the output.
// The last step waits while the output register holds an item that is stalled.
// Reset is synchronous and active low; it clears the phase and sets both config registers to defaults.
module tremolo_lfo_modulator
    import tlm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic        [31:0] i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_sample_in,
    input  logic        [15:0] i_depth_knob,
    input  logic        [15:0] i_rate_knob,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_sample_out
);

    t_dp_cmd w_cmd;

    tlm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    tlm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .i_depth_knob (i_depth_knob),
        .i_rate_knob  (i_rate_knob),
        .o_sample_out (o_sample_out)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for tremolo_lfo_modulator: a directed table, then random phases.
// An in-bench tremolo predictor gives each expected sample that the table does not fix. Depends on tlm_pkg and the RTL.
module tb_top
    import tlm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD = 400;
    localparam int PHASE_ITEMS = 250;
    localparam int NUM_PHASES = 8;
    localparam int NUM_ROWS = 21;

    typedef struct packed {
        bit                 set_cfg;
        logic        [1:0]  wave;
        logic        [31:0] step;
        logic signed [15:0] smp;
        logic        [15:0] depth;
        logic        [15:0] rate;
        bit                 typed;
        logic signed [15:0] want;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic        [31:0] i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_sample_in;
    logic        [15:0] i_depth_knob;
    logic        [15:0] i_rate_knob;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_sample_out;

    logic        [16:0] sine_q16 [0:SINE_DEPTH];
    logic        [1:0]  wave_model;
    logic        [31:0] step_model;
    logic        [31:0] phase_model;
    logic signed [15:0] expected_samples [$];

    int errors;
    int idle_cycles;
    bit hold_request;
    bit hold_done;
    int hold_left;
    int stall_mode;
    int mode_left;

    t_row directed_rows [NUM_ROWS] = '{
        '{1'b0, WAVE_TRIANGLE, 32'd0, 16'sd32767, 16'd0, 16'd0, 1'b1, 16'sd32767},
        '{1'b0, WAVE_TRIANGLE, 32'd0, 16'h8000, 16'd0, 16'd0, 1'b1, 16'h8000},
        '{1'b0, WAVE_TRIANGLE, 32'd0, 16'sd32767, 16'd65535, 16'd0, 1'b1, 16'sd16383},
        '{1'b0, WAVE_TRIANGLE, 32'd0, 16'h8000, 16'd65535, 16'd0, 1'b1, -16'sd16384},
        '{1'b0, WAVE_TRIANGLE, 32'd0, 16'sd0, 16'd65535, 16'd65535, 1'b1, 16'sd0},
        '{1'b0, WAVE_TRIANGLE, 32'd0, 16'sd12345, 16'd40000, 16'd65535, 1'b0, 16'sd0},
        '{1'b1, WAVE_SQUARE, STEP_RESET, 16'sd32767, 16'd65535, 16'd0, 1'b1, 16'sd0},
        '{1'b0, WAVE_SQUARE, 32'd0, 16'h8000, 16'd65535, 16'd0, 1'b1, 16'sd0},
        '{1'b0, WAVE_SQUARE, 32'd0, -16'sd1, 16'd0, 16'd0, 1'b1, -16'sd1},
        '{1'b1, WAVE_SQUARE, 32'h8000_0000, 16'sd20000, 16'd30000, 16'd65535, 1'b0, 16'sd0},
        '{1'b0, WAVE_SQUARE, 32'd0, 16'sd20000, 16'd30000, 16'd0, 1'b0, 16'sd0},
        '{1'b1, WAVE_SLOPED, 32'hFFFF_FFFF, 16'sd32767, 16'd65535, 16'd65535, 1'b0, 16'sd0},
        '{1'b0, WAVE_SLOPED, 32'd0, 16'h8000, 16'd65535, 16'd32768, 1'b0, 16'sd0},
        '{1'b0, WAVE_SLOPED, 32'd0, 16'sd1000, 16'd65535, 16'd12345, 1'b0, 16'sd0},
        '{1'b1, WAVE_SINE, 32'h4000_0000, 16'sd32767, 16'd65535, 16'd65535, 1'b0, 16'sd0},
        '{1'b0, WAVE_SINE, 32'd0, 16'h8000, 16'd65535, 16'd65535, 1'b0, 16'sd0},
        '{1'b0, WAVE_SINE, 32'd0, 16'sd32767, 16'd32768, 16'd65535, 1'b0, 16'sd0},
        '{1'b0, WAVE_SINE, 32'd0, -16'sd12345, 16'd65535, 16'd65535, 1'b0, 16'sd0},
        '{1'b0, WAVE_SINE, 32'd0, 16'sd32767, 16'd65535, 16'd65535, 1'b0, 16'sd0},
        '{1'b1, WAVE_TRIANGLE, 32'd0, 16'sd32767, 16'd65535, 16'd65535, 1'b0, 16'sd0},
        '{1'b0, WAVE_TRIANGLE, 32'd0, 16'h8000, 16'd1, 16'd65535, 1'b0, 16'sd0}
    };

    tremolo_lfo_modulator DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample_in  (i_sample_in),
        .i_depth_knob (i_depth_knob),
        .i_rate_knob  (i_rate_knob),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample_out (o_sample_out)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            x = (64'(HALF_PI_Q30) * 64'(k)) / 64'(SINE_DEPTH);
            x2 = (x * x) >> 30;
            term = x;
            sum = $signed(x);
            for (int n = 1; n <= 6; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
            if (sum < 0) begin
                sum = 64'sd0;
            end
            v = ($unsigned(sum) + 64'd8192) >> 14;
            if (v > 64'(LFO_ONE)) begin
                v = 64'(LFO_ONE);
            end
            sine_q16[k] = v[16:0];
        end
    end

    function automatic logic [16:0] lfo_level(input logic [31:0] p, input logic [1:0] shape);
        logic [63:0] slope;
        logic [63:0] idx;
        logic [16:0] s;
        case (shape)
            WAVE_TRIANGLE: begin
                if (p < PHASE_QUARTER) begin
                    return LFO_MID + 17'(p >> 15);
                end else if (p < PHASE_3QUARTER) begin
                    return LFO_ONE - 17'((p - PHASE_QUARTER) >> 15);
                end
                return 17'((p - PHASE_3QUARTER) >> 15);
            end
            WAVE_SQUARE: begin
                return (p < PHASE_HALF) ? LFO_ONE : 17'd0;
            end
            WAVE_SLOPED: begin
                if (p < EDGE_FALL) begin
                    return LFO_ONE;
                end else if (p < PHASE_HALF) begin
                    slope = (64'(p - EDGE_FALL) * 64'd50) >> 16;
                    return LFO_ONE - slope[16:0];
                end else if (p < EDGE_RISE) begin
                    return 17'd0;
                end
                slope = (64'(p - EDGE_RISE) * 64'd50) >> 16;
                return slope[16:0];
            end
            default: begin
                idx = (64'(p[29:0]) * 64'(SINE_DEPTH)) >> 30;
                s = p[30] ? sine_q16[SINE_DEPTH - int'(idx)] : sine_q16[int'(idx)];
                return p[31] ? (LFO_MID - (s >> 1)) : (LFO_MID + (s >> 1));
            end
        endcase
    endfunction

    // Forms the modulated sample at the current phase, then advances the phase.
    function automatic logic signed [15:0] tremolo_next(input logic [15:0] smp,
            input logic [15:0] depth, input logic [15:0] rate);
        logic [16:0] mag;
        logic [63:0] gain;
        logic [63:0] scaled;
        logic [63:0] inc;
        logic [15:0] res;
        mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        gain = 64'h1_0000_0000 - 64'(depth) * 64'(lfo_level(phase_model, wave_model));
        scaled = (64'(mag) * gain) >> 32;
        res = smp[15] ? 16'(17'h10000 - scaled[16:0]) : scaled[15:0];
        inc = (64'(rate) * 64'(step_model)) >> 16;
        phase_model = phase_model + inc[31:0];
        return $signed(res);
    endfunction

    function automatic logic [15:0] knob_value();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic idle_cycle();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic push_item(input logic signed [15:0] smp, input logic [15:0] depth,
            input logic [15:0] rate, input bit typed, input logic signed [15:0] typed_want);
        logic signed [15:0] predicted;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_sample_in <= smp;
        i_depth_knob <= depth;
        i_rate_knob <= rate;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predicted = tremolo_next(smp, depth, rate);
        expected_samples.push_back(typed ? typed_want : predicted);
    endtask

    task automatic write_config(input logic [1:0] wave, input logic [31:0] step);
        idle_cycle();
        drain();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_WAVEFORM;
        i_cfg_data <= {30'd0, wave};
        @(negedge i_clk);
        i_cfg_index <= REG_STEP;
        i_cfg_data <= step;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        wave_model = wave;
        step_model = step;
    endtask

    always @(negedge i_clk) begin
        if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 1) == 0);
                default: i_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        logic signed [15:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected item, sample_out %0d", $time, o_sample_out);
                errors++;
            end else begin
                want = expected_samples.pop_front();
                if (o_sample_out !== want) begin
                    $display("%0t: sample_out expected %0d, actual %0d",
                             $time, want, o_sample_out);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        int                 burst_left;
        logic signed [15:0] smp;
        logic        [31:0] step;
        errors = 0;
        idle_cycles = 0;
        hold_request = 1'b0;
        hold_done = 1'b0;
        hold_left = 0;
        stall_mode = 0;
        mode_left = 0;
        wave_model = WAVE_TRIANGLE;
        step_model = STEP_RESET;
        phase_model = 32'd0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_WAVEFORM;
        i_cfg_data = 32'd0;
        i_valid = 1'b0;
        i_sample_in = 16'sd0;
        i_depth_knob = 16'd0;
        i_rate_knob = 16'd0;
        i_stall = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].set_cfg) begin
                write_config(directed_rows[r].wave, directed_rows[r].step);
            end
            push_item(directed_rows[r].smp, directed_rows[r].depth, directed_rows[r].rate,
                      directed_rows[r].typed, directed_rows[r].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case ((ph + ph / 4) % 4)
                0: step = 32'hFFFF_FFFF;
                1: step = 32'd0;
                2: step = STEP_RESET;
                default: step = $urandom;
            endcase
            write_config(2'(ph), step);
            if (ph == 3) begin
                @(posedge i_clk);
                hold_request = 1'b1;
            end
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 6 && n == PHASE_ITEMS / 2) begin
                    idle_cycle();
                    drain();
                end
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    if (ph != 3 && ph != 5) begin
                        repeat ($urandom_range(0, 6)) idle_cycle();
                    end
                end
                burst_left--;
                case ($urandom_range(0, 7))
                    0: smp = 16'sd32767;
                    1: smp = 16'h8000;
                    default: smp = 16'($urandom);
                endcase
                push_item(smp, knob_value(), knob_value(), 1'b0, 16'sd0);
            end
        end

        idle_cycle();
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/tlm_pkg.sv
sv/tlm_ctrl.sv
sv/tlm_dp.sv
sv/tremolo_lfo_modulator.sv
tb/tb_top.sv
